// ===== hw/rtl/rst_pkg.sv =====
// Package of types and constants for the retransmit segment tracker.
package rst_pkg;
   localparam int SLOTS_DEFAULT = 8;
   localparam int CFG_IDX_W = 3;
   localparam int CFG_DATA_W = 32;

   localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_SIZE = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT  = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_INIT_SEQ     = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_INIT_RTT     = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_INIT_RTTVAR  = 3'd4;

   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_ACK     = 2'd1;
   localparam logic [1:0] OP_SCAN    = 2'd2;

   localparam logic [1:0] KIND_ENQ      = 2'd0;
   localparam logic [1:0] KIND_ACK      = 2'd1;
   localparam logic [1:0] KIND_SEGMENT  = 2'd2;
   localparam logic [1:0] KIND_SCAN_END = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_ROOM = 2'd1;
   localparam logic [1:0] STATUS_FAILED  = 2'd2;

   typedef enum logic [1:0] {
      SLOT_FREE, SLOT_WAIT_SEND, SLOT_WAIT_ACK, SLOT_FAILED
   } slot_state_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ENQ_CHECK, ST_ENQ_FILL, ST_ACK_TEST, ST_ACK_SRTT, ST_ACK_VAR,
      ST_SCAN_TEST, ST_SCAN_EMIT, ST_RESULT
   } fsm_type;

   typedef struct packed {
      logic [19:0] byte_count;
      logic [31:0] ack_number;
      logic [31:0] now;
      logic [3:0]  tx_credits;
      logic [1:0]  operation;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [31:0] segment_sequence;
      logic [13:0] segment_length;
      logic [2:0]  segment_slot;
      logic [31:0] rtt_estimate;
      logic [31:0] rtt_deviation;
      logic        last;
   } rsp_type;
endpackage

// ===== hw/rtl/rst_if.sv =====
// Valid/ready channel interface carrying one item.
interface rst_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/retransmit_segment_tracker.sv =====
// Top level of the retransmit segment tracker: segment ring, RTT estimator, scan sequencer.
// An enqueue fills one slot per segment or is refused when there is no room, an acknowledgement
// frees each acknowledged segment in turn and a scan visits the slots; each result then waits in an output register.
// The tracker takes one item at a time; one shared 35-bit adder and
// compare unit under the sequencer sets the pace. Reset is synchronous, active high:
// all slots free, head and tail indexes zero and registers back to their reset values.
module retransmit_segment_tracker #(
   parameter int SLOTS = rst_pkg::SLOTS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   rst_if.sink   req,
   rst_if.source rsp,
   input  logic                              csr_write,
   input  logic [rst_pkg::CFG_IDX_W-1:0]     csr_index,
   input  logic [rst_pkg::CFG_DATA_W-1:0]    csr_data
);
   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   rst_pkg::fsm_type state_ff, state_in;
   rst_pkg::req_type req_ff;

   logic [13:0] seg_size_ff;
   logic [7:0]  retry_ff;

   rst_pkg::slot_state_type slot_state_ff [SLOTS];
   logic [31:0] slot_seq_mem [SLOTS];
   logic [13:0] slot_len_mem [SLOTS];
   logic [7:0]  slot_tries_mem [SLOTS];
   logic [31:0] slot_ts_mem [SLOTS];

   logic [IW-1:0] head_ff, tail_ff, idx_ff;
   logic [CW-1:0] free_ff, visit_ff;
   logic [31:0] next_seq_ff, srtt_ff, var_ff, sample_ff;
   logic [19:0] count_ff;
   logic [3:0]  credits_ff;
   logic [33:0] acc_ff;
   logic [1:0]  status_ff;
   logic        out_valid_ff;
   rst_pkg::rsp_type out_ff;

   // Effective segment size.
   logic [13:0] seg_eff;
   always_comb begin
      if (seg_size_ff == 14'd0) seg_eff = 14'd1;
      else if (seg_size_ff > 14'd8192) seg_eff = 14'd8192;
      else seg_eff = seg_size_ff;
   end

   // Shared unit: 35-bit adder with an operand mux chosen by state.
   logic [34:0] alu_a, alu_b, alu_sum;
   logic [31:0] cur_seq, cur_ts;
   logic [13:0] cur_len;
   logic [7:0]  cur_tries;
   rst_pkg::slot_state_type cur_state;
   logic [31:0] age;
   always_comb begin
      cur_state = slot_state_ff[idx_ff];
      cur_seq = slot_seq_mem[idx_ff];
      cur_len = slot_len_mem[idx_ff];
      cur_tries = slot_tries_mem[idx_ff];
      cur_ts = slot_ts_mem[idx_ff];
      age = req_ff.now - cur_ts;
      alu_a = '0;
      alu_b = '0;
      case (state_ff)
         rst_pkg::ST_ACK_TEST: begin
            alu_a = {3'b0, req_ff.ack_number};
            alu_b = ~{3'b0, cur_seq + {18'd0, cur_len}} + 35'd1;
         end
         rst_pkg::ST_ACK_SRTT: begin
            alu_a = {srtt_ff, 3'b0} - {3'b0, srtt_ff};
            alu_b = {3'b0, sample_ff};
         end
         rst_pkg::ST_ACK_VAR: begin
            alu_a = {3'b0, var_ff} + {2'b0, var_ff, 1'b0};
            alu_b = (sample_ff >= srtt_ff) ? {3'b0, sample_ff - srtt_ff}
                                           : {3'b0, srtt_ff - sample_ff};
         end
         rst_pkg::ST_SCAN_TEST: begin
            alu_a = {3'b0, srtt_ff};
            alu_b = {1'b0, var_ff, 2'b0};
         end
         default: begin
            alu_a = '0;
            alu_b = '0;
         end
      endcase
      alu_sum = alu_a + alu_b;
   end

   logic [33:0] room;
   assign room = {14'd0, 20'(free_ff) * 20'(seg_eff)};
   logic [19:0] seg_len;
   assign seg_len = (count_ff > {6'd0, seg_eff}) ? {6'd0, seg_eff} : count_ff;
   logic ack_ok, due;
   assign ack_ok = (free_ff != CW'(SLOTS)) && (cur_state == rst_pkg::SLOT_WAIT_ACK)
                   && !alu_sum[31];
   assign due = !(cur_state == rst_pkg::SLOT_WAIT_ACK && {3'b0, age} <= alu_sum);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rst_pkg::ST_IDLE:
            if (req.valid && req.ready) begin
               case (req.payload.operation)
                  rst_pkg::OP_ENQUEUE: state_in = rst_pkg::ST_ENQ_CHECK;
                  rst_pkg::OP_ACK:     state_in = rst_pkg::ST_ACK_TEST;
                  rst_pkg::OP_SCAN:    state_in = rst_pkg::ST_SCAN_TEST;
                  default:             state_in = rst_pkg::ST_IDLE;
               endcase
            end
         rst_pkg::ST_ENQ_CHECK:
            state_in = ({14'd0, req_ff.byte_count} > room) ? rst_pkg::ST_RESULT
                                                           : rst_pkg::ST_ENQ_FILL;
         rst_pkg::ST_ENQ_FILL:
            if (count_ff == 20'd0 || free_ff == '0) state_in = rst_pkg::ST_RESULT;
         rst_pkg::ST_ACK_TEST:
            state_in = ack_ok ? rst_pkg::ST_ACK_SRTT : rst_pkg::ST_RESULT;
         rst_pkg::ST_ACK_SRTT: state_in = rst_pkg::ST_ACK_VAR;
         rst_pkg::ST_ACK_VAR:  state_in = rst_pkg::ST_ACK_TEST;
         rst_pkg::ST_SCAN_TEST:
            if (visit_ff == '0 || credits_ff == 4'd0) state_in = rst_pkg::ST_RESULT;
            else state_in = rst_pkg::ST_SCAN_EMIT;
         rst_pkg::ST_SCAN_EMIT:
            if (!acc_ff[33]) begin
               state_in = rst_pkg::ST_SCAN_TEST;
            end else if (cur_tries > retry_ff) begin
               state_in = rst_pkg::ST_RESULT;
            end else if (!out_valid_ff || rsp.ready) begin
               state_in = rst_pkg::ST_SCAN_TEST;
            end
         rst_pkg::ST_RESULT:
            if (!out_valid_ff || rsp.ready) state_in = rst_pkg::ST_IDLE;
         default: state_in = rst_pkg::ST_IDLE;
      endcase
   end

   // Output decode.
   always_comb begin
      req.ready = (state_ff == rst_pkg::ST_IDLE);
      rsp.valid = out_valid_ff;
      rsp.payload = out_ff;
   end

   logic out_free;
   assign out_free = !out_valid_ff || rsp.ready;

   // A new result enters the output register in this cycle.
   logic out_load;
   assign out_load = out_free &&
                     ((state_ff == rst_pkg::ST_SCAN_EMIT && acc_ff[33] &&
                       !(cur_tries > retry_ff)) || state_ff == rst_pkg::ST_RESULT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rst_pkg::ST_IDLE;
         seg_size_ff <= 14'd1024;
         retry_ff <= 8'd5;
         next_seq_ff <= '0;
         srtt_ff <= 32'd200;
         var_ff <= 32'd50;
         head_ff <= '0;
         tail_ff <= '0;
         free_ff <= CW'(SLOTS);
         out_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) slot_state_ff[i] <= rst_pkg::SLOT_FREE;
      end else begin
         state_ff <= state_in;
         if (out_load) out_valid_ff <= 1'b1;
         else if (rsp.ready) out_valid_ff <= 1'b0;
         if (csr_write) begin
            case (csr_index)
               rst_pkg::REG_SEGMENT_SIZE: seg_size_ff <= csr_data[13:0];
               rst_pkg::REG_RETRY_LIMIT:  retry_ff <= csr_data[7:0];
               rst_pkg::REG_INIT_SEQ:     next_seq_ff <= csr_data;
               rst_pkg::REG_INIT_RTT:     srtt_ff <= csr_data;
               rst_pkg::REG_INIT_RTTVAR:  var_ff <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            rst_pkg::ST_IDLE:
               if (req.valid) begin
                  req_ff <= req.payload;
                  count_ff <= req.payload.byte_count;
                  credits_ff <= req.payload.tx_credits;
                  idx_ff <= (req.payload.operation == rst_pkg::OP_ENQUEUE) ? tail_ff
                                                                            : head_ff;
                  visit_ff <= CW'(SLOTS) - free_ff;
                  sample_ff <= req.payload.now - slot_ts_mem[head_ff];
                  status_ff <= rst_pkg::STATUS_OK;
               end
            rst_pkg::ST_ENQ_CHECK:
               if ({14'd0, req_ff.byte_count} > room) status_ff <= rst_pkg::STATUS_NO_ROOM;
            rst_pkg::ST_ENQ_FILL:
               if (count_ff != 20'd0 && free_ff != '0) begin
                  slot_state_ff[tail_ff] <= rst_pkg::SLOT_WAIT_SEND;
                  next_seq_ff <= next_seq_ff + {12'd0, seg_len};
                  count_ff <= count_ff - seg_len;
                  free_ff <= free_ff - 1'b1;
                  tail_ff <= (tail_ff == IW'(SLOTS - 1)) ? '0 : tail_ff + 1'b1;
               end
            rst_pkg::ST_ACK_SRTT: srtt_ff <= alu_sum[34:3];
            rst_pkg::ST_ACK_VAR: begin
               var_ff <= alu_sum[33:2];
               slot_state_ff[idx_ff] <= rst_pkg::SLOT_FREE;
               free_ff <= free_ff + 1'b1;
               idx_ff <= (idx_ff == IW'(SLOTS - 1)) ? '0 : idx_ff + 1'b1;
               head_ff <= (idx_ff == IW'(SLOTS - 1)) ? '0 : idx_ff + 1'b1;
            end
            rst_pkg::ST_SCAN_TEST:
               acc_ff <= {due, 33'd0};
            rst_pkg::ST_SCAN_EMIT:
               if (!acc_ff[33]) begin
                  visit_ff <= visit_ff - 1'b1;
                  idx_ff <= (idx_ff == IW'(SLOTS - 1)) ? '0 : idx_ff + 1'b1;
               end else if (cur_tries > retry_ff) begin
                  slot_state_ff[idx_ff] <= rst_pkg::SLOT_FAILED;
                  status_ff <= rst_pkg::STATUS_FAILED;
               end else if (out_free) begin
                  out_ff <= '{kind: rst_pkg::KIND_SEGMENT, status: rst_pkg::STATUS_OK,
                              segment_sequence: cur_seq, segment_length: cur_len,
                              segment_slot: 3'(idx_ff), rtt_estimate: srtt_ff,
                              rtt_deviation: var_ff, last: 1'b0};
                  slot_state_ff[idx_ff] <= rst_pkg::SLOT_WAIT_ACK;
                  credits_ff <= credits_ff - 1'b1;
                  visit_ff <= visit_ff - 1'b1;
                  idx_ff <= (idx_ff == IW'(SLOTS - 1)) ? '0 : idx_ff + 1'b1;
               end
            rst_pkg::ST_RESULT:
               if (out_free) begin
                  out_ff <= '{kind: (req_ff.operation == rst_pkg::OP_ENQUEUE) ?
                                    rst_pkg::KIND_ENQ :
                                    (req_ff.operation == rst_pkg::OP_ACK) ?
                                    rst_pkg::KIND_ACK : rst_pkg::KIND_SCAN_END,
                              status: status_ff, segment_sequence: '0,
                              segment_length: '0, segment_slot: '0,
                              rtt_estimate: srtt_ff, rtt_deviation: var_ff, last: 1'b1};
               end
            default: ;
         endcase
      end
   end

   // Slot payload memory, no reset.
   always_ff @(posedge clock) begin
      if (state_ff == rst_pkg::ST_ENQ_FILL && count_ff != 20'd0 && free_ff != '0) begin
         slot_seq_mem[tail_ff] <= next_seq_ff;
         slot_len_mem[tail_ff] <= seg_len[13:0];
         slot_tries_mem[tail_ff] <= '0;
         slot_ts_mem[tail_ff] <= req_ff.now;
      end else if (state_ff == rst_pkg::ST_SCAN_EMIT && acc_ff[33] &&
                   !(cur_tries > retry_ff) && out_free) begin
         slot_ts_mem[idx_ff] <= req_ff.now;
         if (cur_tries != 8'hFF) slot_tries_mem[idx_ff] <= cur_tries + 8'd1;
      end
   end

   a_free_range: assert property (@(posedge clock) disable iff (reset)
      free_ff <= CW'(SLOTS)) else $error("free slot count out of range");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == rst_pkg::ST_IDLE) else $error("ready outside idle");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp.ready |=> out_valid_ff) else $error("result dropped");
   a_ring: assert property (@(posedge clock) disable iff (reset)
      (free_ff == CW'(SLOTS) || free_ff == '0) |-> head_ff == tail_ff)
      else $error("ring indexes disagree with fill count");
endmodule
